### hdl/pal_yuv_line_average_to_rgb_top_macros.svh
// Assertion macros for the line-average YUV to RGB block.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef PAL_YUV_LINE_AVERAGE_TO_RGB_TOP_MACROS_SVH
`define PAL_YUV_LINE_AVERAGE_TO_RGB_TOP_MACROS_SVH

`ifndef SYNTH

`define PYL_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define PYL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define PYL_ASSERT_IMPLY(label, ante, cons, msg)

`define PYL_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### hdl/pylrgb_pkg.sv
`timescale 1ns / 1ps
// Types, constants and the clamp function for the line-average YUV to RGB block.
// No dependencies.
package pylrgb_pkg;

    localparam int LINE_WORDS = 1024;
    localparam int ADDR_W     = $clog2(LINE_WORDS);
    localparam int COLUMN_W   = 10;
    localparam int WORD_W     = 32;
    localparam int HALF_W     = 16;
    localparam int BYTE_W     = 8;

    localparam int RGB_BIAS  = 32'h8020;
    localparam int G_COEF_U  = -3182;
    localparam int G_COEF_V  = -8346;
    localparam int G_ROUND   = 32'h80000;
    localparam int G_YOFS    = 32'h10000000;
    localparam int G_CSCALE  = 32'h4000;
    localparam int CH_MAX    = 32'hffff;

    // Green sum: y*2^14 - 3182*u - 8346*v + offset, all within 33 bits signed
    localparam int G_W       = 33;
    localparam int PROD_W    = 30;
    localparam int G_SHIFT   = 20;
    localparam int RB_SHIFT  = 6;
    localparam int RB_W      = 18;
    localparam int G_OFS     = G_ROUND - G_YOFS - G_CSCALE * (G_COEF_U + G_COEF_V);

    typedef struct packed {
        logic [COLUMN_W-1:0] column;
        logic [WORD_W-1:0]   luma_pair;
        logic [WORD_W-1:0]   u_pair;
        logic [WORD_W-1:0]   v_pair;
    } t_pix_in;

    typedef struct packed {
        logic [BYTE_W-1:0] red_first;
        logic [BYTE_W-1:0] green_first;
        logic [BYTE_W-1:0] blue_first;
        logic [BYTE_W-1:0] red_second;
        logic [BYTE_W-1:0] green_second;
        logic [BYTE_W-1:0] blue_second;
    } t_pix_out;

    // Floor shift, then saturate to one byte; negative goes to zero
    function automatic logic [BYTE_W-1:0] clamp_byte(input logic signed [G_W-1:0] t,
                                                     input int sh);
        logic signed [G_W-1:0] q;
        begin
            q = t >>> sh;
            if (t < 0) begin
                clamp_byte = '0;
            end else if (q > G_W'(255)) begin
                clamp_byte = '1;
            end else begin
                clamp_byte = q[BYTE_W-1:0];
            end
        end
    endfunction

endpackage

### hdl/pal_yuv_line_average_to_rgb_top.sv
`timescale 1ns / 1ps
// Delay-line chroma average and YUV to RGB conversion, two pixels per word.
// Depends on pylrgb_pkg and pal_yuv_line_average_to_rgb_top_macros.svh.
//
//  channel | valid       | stall       | word
//  --------+-------------+-------------+----------------------------
//  in      | i_in_valid  | o_in_stall  | i_in_data  (t_pix_in)
//  out     | o_out_valid | i_out_stall | o_out_data (t_pix_out)
//
// One word per cycle sustained while the output is not stalled and no sweep runs.
// Each word passes the line store read, the chroma add, the green multipliers,
// the green sum and the clamp, one register stage each.
// After reset all LINE_WORDS (1024) line store entries are swept to zero, one
// entry per cycle, while o_in_stall is high.
// An output stall freezes the whole pipeline; nothing is dropped or repeated.
`include "pal_yuv_line_average_to_rgb_top_macros.svh"

module pal_yuv_line_average_to_rgb_top
    import pylrgb_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_pix_in  i_in_data,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    output t_pix_out o_out_data
);

    // Line store
    logic [WORD_W-1:0] r_u_line [LINE_WORDS];
    logic [WORD_W-1:0] r_v_line [LINE_WORDS];

    logic              r_clearing;
    logic [ADDR_W-1:0] r_clr_addr;

    logic              w_adv;
    logic              w_acc;
    logic [ADDR_W-1:0] w_col;
    logic              w_we;
    logic [ADDR_W-1:0] w_waddr;
    logic [WORD_W-1:0] w_wu;
    logic [WORD_W-1:0] w_wv;

    // Stage 1: raw words and previous line words
    logic              r_vld1;
    logic [WORD_W-1:0] r_y1;
    logic [WORD_W-1:0] r_u_new1;
    logic [WORD_W-1:0] r_v_new1;
    logic [WORD_W-1:0] r_u_prev1;
    logic [WORD_W-1:0] r_v_prev1;

    // Stage 2: summed chroma
    logic              r_vld2;
    logic [WORD_W-1:0] r_y2;
    logic [WORD_W-1:0] r_u2;
    logic [WORD_W-1:0] r_v2;

    // Stage 3: red/blue sums and green products, per half
    logic                     r_vld3;
    logic [HALF_W-1:0]        r_y3    [2];
    logic signed [RB_W-1:0]   r_red3  [2];
    logic signed [RB_W-1:0]   r_blue3 [2];
    logic [PROD_W-1:0]        r_pu3   [2];
    logic [PROD_W-1:0]        r_pv3   [2];

    // Stage 4: green sum, red/blue clamped
    logic                     r_vld4;
    logic signed [G_W-1:0]    r_g4    [2];
    logic [BYTE_W-1:0]        r_red4  [2];
    logic [BYTE_W-1:0]        r_blue4 [2];

    logic signed [RB_W-1:0]   n_red   [2];
    logic signed [RB_W-1:0]   n_blue  [2];
    logic signed [G_W-1:0]    n_g     [2];

    t_pix_out r_out;
    logic     r_out_vld;

    assign w_adv      = !r_out_vld || !i_out_stall;
    assign o_in_stall = r_clearing || !w_adv;
    assign w_acc      = i_in_valid && !o_in_stall;
    assign w_col      = ADDR_W'(i_in_data.column % LINE_WORDS);

    assign w_we    = r_clearing || w_acc;
    assign w_waddr = r_clearing ? r_clr_addr : w_col;
    assign w_wu    = r_clearing ? '0 : i_in_data.u_pair;
    assign w_wv    = r_clearing ? '0 : i_in_data.v_pair;

    // Clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (r_clr_addr == ADDR_W'(LINE_WORDS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    // Read returns the old entry when the same address is written in this cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_u_line[w_waddr] <= w_wu;
            r_v_line[w_waddr] <= w_wv;
        end
        if (w_adv) begin
            r_u_prev1 <= r_u_line[w_col];
            r_v_prev1 <= r_v_line[w_col];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1    <= 1'b0;
            r_vld2    <= 1'b0;
            r_vld3    <= 1'b0;
            r_vld4    <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_vld1    <= w_acc;
            r_vld2    <= r_vld1;
            r_vld3    <= r_vld2;
            r_vld4    <= r_vld3;
            r_out_vld <= r_vld4;
        end
    end

    always_comb begin
        for (int h = 0; h < 2; h++) begin
            n_red[h]  = $signed(RB_W'(r_y2[h*HALF_W +: HALF_W]) + RB_W'(r_v2[h*HALF_W +: HALF_W])
                                - RB_W'(RGB_BIAS));
            n_blue[h] = $signed(RB_W'(r_y2[h*HALF_W +: HALF_W]) + RB_W'(r_u2[h*HALF_W +: HALF_W])
                                - RB_W'(RGB_BIAS));
            n_g[h]    = $signed(G_W'({r_y3[h], 14'b0})) - $signed(G_W'(r_pu3[h]))
                        - $signed(G_W'(r_pv3[h])) + $signed(G_W'(G_OFS));
        end
    end

    // Data path, frozen as a whole while the output word is stalled
    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_y1     <= i_in_data.luma_pair;
            r_u_new1 <= i_in_data.u_pair;
            r_v_new1 <= i_in_data.v_pair;

            r_y2 <= r_y1;
            r_u2 <= r_u_new1 + r_u_prev1;
            r_v2 <= r_v_new1 + r_v_prev1;

            for (int h = 0; h < 2; h++) begin
                r_y3[h]    <= r_y2[h*HALF_W +: HALF_W];
                r_red3[h]  <= n_red[h];
                r_blue3[h] <= n_blue[h];
                r_pu3[h]   <= PROD_W'(r_u2[h*HALF_W +: HALF_W]) * PROD_W'(-G_COEF_U);
                r_pv3[h]   <= PROD_W'(r_v2[h*HALF_W +: HALF_W]) * PROD_W'(-G_COEF_V);

                r_g4[h]    <= n_g[h];
                r_red4[h]  <= clamp_byte(G_W'(r_red3[h]), RB_SHIFT);
                r_blue4[h] <= clamp_byte(G_W'(r_blue3[h]), RB_SHIFT);
            end

            r_out.red_first    <= r_red4[0];
            r_out.green_first  <= clamp_byte(r_g4[0], G_SHIFT);
            r_out.blue_first   <= r_blue4[0];
            r_out.red_second   <= r_red4[1];
            r_out.green_second <= clamp_byte(r_g4[1], G_SHIFT);
            r_out.blue_second  <= r_blue4[1];
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    `PYL_ASSERT_IMPLY(a_clear_empty, r_clearing,
        !(r_vld1 || r_vld2 || r_vld3 || r_vld4 || r_out_vld),
        "word in pipeline during line store sweep")
    `PYL_ASSERT_IMPLY(a_clear_full_sweep, $fell(r_clearing),
        $past(r_clr_addr) == ADDR_W'(LINE_WORDS - 1),
        "line store sweep ended early")
    `PYL_ASSERT_IMPLY(a_out_from_s4, $rose(o_out_valid), $past(r_vld4) && $past(w_adv),
        "output word without a word in the last stage")
    `PYL_ASSERT_NEXT(a_stall_hold_s4, r_out_vld && i_out_stall && r_vld4, r_vld4,
        "stage four word lost under stall")

endmodule
